@@ rtl/utf8e_pkg.sv @@
// Package with the shared types, limits and lead-byte prefixes of the UTF-8 encoder.
package utf8e_pkg;

  typedef logic [30:0] code_t;
  typedef logic [2:0]  len_t;
  typedef logic [7:0]  byte_t;

  localparam code_t LimOne   = 31'h0000007f;
  localparam code_t LimTwo   = 31'h000007ff;
  localparam code_t LimThree = 31'h0000ffff;
  localparam code_t LimFour  = 31'h001fffff;
  localparam code_t LimFive  = 31'h03ffffff;

  localparam len_t LenOne   = 3'd1;
  localparam len_t LenTwo   = 3'd2;
  localparam len_t LenThree = 3'd3;
  localparam len_t LenFour  = 3'd4;
  localparam len_t LenFive  = 3'd5;
  localparam len_t LenSix   = 3'd6;

  localparam byte_t PrefixTwo   = 8'hc0;
  localparam byte_t PrefixThree = 8'he0;
  localparam byte_t PrefixFour  = 8'hf0;
  localparam byte_t PrefixFive  = 8'hf8;
  localparam byte_t PrefixSix   = 8'hfc;
  localparam byte_t ContMark    = 8'h80;
  localparam byte_t ContMask    = 8'h3f;

  typedef struct packed {
    logic first;
    len_t len;
    len_t rem;
  } sel_t;

  function automatic byte_t lead_prefix(input len_t len);
    byte_t p;
    case (len)
      LenTwo:   p = PrefixTwo;
      LenThree: p = PrefixThree;
      LenFour:  p = PrefixFour;
      LenFive:  p = PrefixFive;
      LenSix:   p = PrefixSix;
      default:  p = 8'h00;
    endcase
    return p;
  endfunction

endpackage

@@ rtl/utf8e_len.sv @@
// Sequence length classifier that compares a code point against the range limits.
module utf8e_len (
  input  utf8e_pkg::code_t code_i,
  output utf8e_pkg::len_t  len_o
);

  always_comb begin
    if (code_i <= utf8e_pkg::LimOne) begin
      len_o = utf8e_pkg::LenOne;
    end else if (code_i <= utf8e_pkg::LimTwo) begin
      len_o = utf8e_pkg::LenTwo;
    end else if (code_i <= utf8e_pkg::LimThree) begin
      len_o = utf8e_pkg::LenThree;
    end else if (code_i <= utf8e_pkg::LimFour) begin
      len_o = utf8e_pkg::LenFour;
    end else if (code_i <= utf8e_pkg::LimFive) begin
      len_o = utf8e_pkg::LenFive;
    end else begin
      len_o = utf8e_pkg::LenSix;
    end
  end

endmodule

@@ rtl/utf8e_byte.sv @@
// Byte former that builds the lead or continuation byte for one position.
module utf8e_byte (
  input  utf8e_pkg::code_t code_i,
  input  utf8e_pkg::sel_t  sel_i,
  output utf8e_pkg::byte_t byte_o
);

  utf8e_pkg::byte_t slice;

  always_comb begin
    case (sel_i.rem)
      3'd0:    slice = code_i[7:0];
      3'd1:    slice = code_i[13:6];
      3'd2:    slice = code_i[19:12];
      3'd3:    slice = code_i[25:18];
      3'd4:    slice = {1'b0, code_i[30:24]};
      3'd5:    slice = {7'b0000000, code_i[30]};
      default: slice = 8'h00;
    endcase
  end

  always_comb begin
    if (!sel_i.first) begin
      byte_o = utf8e_pkg::ContMark | (slice & utf8e_pkg::ContMask);
    end else if (sel_i.len == utf8e_pkg::LenOne) begin
      byte_o = slice;
    end else begin
      byte_o = utf8e_pkg::lead_prefix(sel_i.len) | slice;
    end
  end

endmodule

@@ rtl/utf8_encoder_top.sv @@
// Top level of the UTF-8 encoder with sequences of up to six bytes.
//
// The input channel takes one beat per character: a 31-bit code point and a
// text end flag. The output channel gives one beat per encoded byte, lead byte
// first, with char_last_o on the final byte of each character and text_last_o
// copying the text end flag on that byte only.
// An accepted character sits in a hold register that feeds the byte former,
// and each formed byte is loaded into the output register.
// A character of N bytes stays in the hold register for N advances, one per
// byte, so single-byte characters stream at one beat per cycle while the
// receiver does not stall, and a new character is taken in the same cycle
// that the last byte of the previous one moves to the output register.
// When the receiver stalls, the output beat holds and the hold register waits,
// so the input stalls as soon as a character is waiting.
// Reset empties both registers; no beat is pending afterward.
module utf8_encoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [30:0] code_point_i,
  input  logic        text_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  byte_value_o,
  output logic        char_last_o,
  output logic        text_last_o
);

  logic             hold_valid_q;
  utf8e_pkg::code_t code_q;
  logic             end_q;
  utf8e_pkg::sel_t  sel_q;
  utf8e_pkg::len_t  in_len;
  utf8e_pkg::byte_t byte_d;

  logic             out_valid_q;
  utf8e_pkg::byte_t byte_q;
  logic             char_last_q;
  logic             text_last_q;

  logic out_free;
  logic advance;
  logic hold_last;
  logic in_acc;

  utf8e_len u_len (
    .code_i (code_point_i),
    .len_o  (in_len)
  );

  utf8e_byte u_byte (
    .code_i (code_q),
    .sel_i  (sel_q),
    .byte_o (byte_d)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = hold_valid_q && out_free;
  assign hold_last  = (sel_q.rem == 3'd0);
  assign in_stall_o = hold_valid_q && !(advance && hold_last);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else if (in_acc) begin
      hold_valid_q <= 1'b1;
    end else if (advance && hold_last) begin
      hold_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      code_q    <= code_point_i;
      end_q     <= text_end_i;
      sel_q.first <= 1'b1;
      sel_q.len <= in_len;
      sel_q.rem <= in_len - 3'd1;
    end else if (advance) begin
      sel_q.first <= 1'b0;
      sel_q.rem   <= sel_q.rem - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= hold_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      byte_q      <= byte_d;
      char_last_q <= hold_last;
      text_last_q <= hold_last && end_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign byte_value_o = byte_q;
  assign char_last_o  = char_last_q;
  assign text_last_o  = text_last_q;

endmodule

@@ rtl/utf8e_checker.sv @@
// Port checker for the UTF-8 encoder and its bind to the top level.
module utf8e_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] byte_value_o,
  input logic       char_last_o,
  input logic       text_last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(byte_value_o))
    else $error("Stalled output beat changed.");

  a_text_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !char_last_o |-> !text_last_o)
    else $error("Text end flagged on a byte that does not end its character.");

  a_ascii_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_value_o[7] |-> char_last_o)
    else $error("Single-byte character not marked as its final byte.");

  a_lead_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (byte_value_o[7:6] == 2'b11) |-> !char_last_o)
    else $error("Lead byte of a multi-byte character marked as final.");

endmodule

bind utf8_encoder_top utf8e_checker u_utf8e_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .byte_value_o (byte_value_o),
  .char_last_o  (char_last_o),
  .text_last_o  (text_last_o)
);
